// ===== src/cti_pkg.sv =====
`timescale 1ns / 1ps
// cti_pkg: shared widths, register indexes, flag struct, count clamp and mu-law table
// for the channel time integrator. Depends on nothing.

package cti_pkg;

   localparam int DEFAULT_MAX_CHANNELS    = 1024;
   localparam int DEFAULT_MAX_INTEGRATION = 1024;

   localparam int SAMPLE_W      = 16;
   localparam int VALUE_W       = 17;  // expanded sample, unsigned Q1.16 up to 1.0
   localparam int CHANNEL_W     = 10;  // rsp_channel port
   localparam int CFG_COUNT_W   = 11;
   localparam int CFG_COUNT_MAX = (2 ** CFG_COUNT_W) - 1;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 11;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_CHANNELS       = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRATION_LENGTH = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_SAMPLES       = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_MULAW_ENABLE       = CSR_INDEX_W'(3);

   localparam logic [CFG_COUNT_W-1:0] RESET_NUM_CHANNELS       = CFG_COUNT_W'(1024);
   localparam logic [CFG_COUNT_W-1:0] RESET_INTEGRATION_LENGTH = CFG_COUNT_W'(1);

   typedef struct packed {
      logic last_chan;
      logic last_spec;
   } cti_flags_type;

   typedef logic [VALUE_W-1:0] cti_table_type [256];

   // zero acts as one, anything above the limit acts as the limit
   function automatic logic [CFG_COUNT_W-1:0] clamp_count(
      input logic [CFG_COUNT_W-1:0] raw,
      input logic [CFG_COUNT_W-1:0] limit);
      logic [CFG_COUNT_W-1:0] result;
      unique if (raw == '0) begin
         result = CFG_COUNT_W'(1);
      end else if (raw > limit) begin
         result = limit;
      end else begin
         result = raw;
      end
      return result;
   endfunction

   // mu 255 expansion: round(65536 * (256^(b/255) - 1) / 255)
   function automatic cti_table_type build_mulaw_table();
      cti_table_type t;
      real           p;
      for (int b = 0; b < 256; b++) begin
         p    = 2.0 ** (real'(8 * b) / 255.0);
         t[b] = VALUE_W'($rtoi((65536.0 * (p - 1.0) / 255.0) + 0.5));
      end
      return t;
   endfunction

   localparam cti_table_type MULAW_TABLE = build_mulaw_table();

endpackage

// ===== src/cti_front.sv =====
`timescale 1ns / 1ps
// cti_front: takes input items, expands samples, tracks channel and spectrum position
// and tags each item with its last-channel / last-spectrum flags. Uses cti_pkg.

module cti_front
   import cti_pkg::*;
#(
   parameter int MAX_CHANNELS    = DEFAULT_MAX_CHANNELS,
   parameter int MAX_INTEGRATION = DEFAULT_MAX_INTEGRATION
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic [CFG_COUNT_W-1:0]                          cfg_num_channels,
   input  logic [CFG_COUNT_W-1:0]                          cfg_integration_length,
   input  logic                                            cfg_wide_samples,
   input  logic                                            cfg_mulaw_enable,
   input  logic                                            enable,
   input  logic                                            req_valid,
   output logic                                            req_ready,
   input  logic [SAMPLE_W-1:0]                             req_sample,
   output logic                                            push_valid,
   input  logic                                            push_ready,
   output logic [VALUE_W-1:0]                              push_value,
   output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] push_channel,
   output cti_flags_type                                   push_flags
);

   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int SPEC_W = (MAX_INTEGRATION > 1) ? $clog2(MAX_INTEGRATION) : 1;
   localparam int CMP_W0 = (CH_W > SPEC_W) ? CH_W : SPEC_W;
   localparam int CMP_W  = ((CMP_W0 > CFG_COUNT_W) ? CMP_W0 : CFG_COUNT_W) + 1;
   localparam logic [CFG_COUNT_W-1:0] CH_LIMIT =
      CFG_COUNT_W'((MAX_CHANNELS < CFG_COUNT_MAX) ? MAX_CHANNELS : CFG_COUNT_MAX);
   localparam logic [CFG_COUNT_W-1:0] SPEC_LIMIT =
      CFG_COUNT_W'((MAX_INTEGRATION < CFG_COUNT_MAX) ? MAX_INTEGRATION : CFG_COUNT_MAX);

   logic [CH_W-1:0]        ch_pos_ff, ch_pos_in;
   logic [SPEC_W-1:0]      spec_pos_ff, spec_pos_in;
   logic [CFG_COUNT_W-1:0] nc_lim, nl_lim;
   logic                   last_chan, last_spec, accept;

   assign req_ready  = enable && push_ready;
   assign push_valid = req_valid && enable;
   assign accept     = req_valid && req_ready;

   assign nc_lim    = clamp_count(cfg_num_channels, CH_LIMIT);
   assign nl_lim    = clamp_count(cfg_integration_length, SPEC_LIMIT);
   assign last_chan = (CMP_W'(ch_pos_ff) + CMP_W'(1)) >= CMP_W'(nc_lim);
   assign last_spec = (CMP_W'(spec_pos_ff) + CMP_W'(1)) >= CMP_W'(nl_lim);

   always_comb begin
      if (cfg_wide_samples) begin
         push_value = VALUE_W'(req_sample);
      end else if (cfg_mulaw_enable) begin
         push_value = MULAW_TABLE[req_sample[7:0]];
      end else begin
         push_value = VALUE_W'(req_sample[7:0]);
      end
   end

   assign push_channel         = ch_pos_ff;
   assign push_flags.last_chan = last_chan;
   assign push_flags.last_spec = last_spec;

   always_comb begin
      ch_pos_in   = ch_pos_ff;
      spec_pos_in = spec_pos_ff;
      if (accept) begin
         if (last_chan) begin
            ch_pos_in   = '0;
            spec_pos_in = last_spec ? '0 : spec_pos_ff + SPEC_W'(1);
         end else begin
            ch_pos_in = ch_pos_ff + CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_pos_ff   <= '0;
         spec_pos_ff <= '0;
      end else begin
         ch_pos_ff   <= ch_pos_in;
         spec_pos_ff <= spec_pos_in;
      end
   end

endmodule

// ===== src/cti_queue.sv =====
`timescale 1ns / 1ps
// cti_queue: small register FIFO between the front and back parts.
// Uses cti_pkg for its default depth.

module cti_queue
   import cti_pkg::*;
#(
   parameter int DATA_W = 1,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/cti_back.sv =====
`timescale 1ns / 1ps
// cti_back: per-channel sum memory with read-modify-write, bit-serial divider for the
// average and the result register. Clears the sum memory after reset. Uses cti_pkg.

module cti_back
   import cti_pkg::*;
#(
   parameter int MAX_CHANNELS    = DEFAULT_MAX_CHANNELS,
   parameter int MAX_INTEGRATION = DEFAULT_MAX_INTEGRATION
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic [CFG_COUNT_W-1:0]                          cfg_integration_length,
   input  logic                                            pop_valid,
   output logic                                            pop_ready,
   input  logic [VALUE_W-1:0]                              pop_value,
   input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] pop_channel,
   input  cti_flags_type                                   pop_flags,
   output logic                                            mem_ready,
   output logic                                            rsp_valid,
   input  logic                                            rsp_ready,
   output logic [VALUE_W-1:0]                              rsp_average,
   output logic [CHANNEL_W-1:0]                            rsp_channel,
   output logic                                            rsp_last_channel
);

   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int SUM_W  = ((MAX_INTEGRATION > 1) ? $clog2(MAX_INTEGRATION) : 0) + VALUE_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [CFG_COUNT_W-1:0] SPEC_LIMIT =
      CFG_COUNT_W'((MAX_INTEGRATION < CFG_COUNT_MAX) ? MAX_INTEGRATION : CFG_COUNT_MAX);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_ACCUM  = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_OUTPUT = 5'b10000
   } cti_state_type;

   cti_state_type          state_ff, state_in;
   logic [CH_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [CH_W-1:0]        channel_ff, channel_in;
   cti_flags_type          flags_ff, flags_in;
   logic [SUM_W-1:0]       div_ff, div_in;       // dividend in, quotient out
   logic [CFG_COUNT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]     rsp_avg_ff, rsp_avg_in;
   logic [CHANNEL_W-1:0]   rsp_ch_ff, rsp_ch_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [SUM_W-1:0]       sums_mem [MAX_CHANNELS];
   logic [SUM_W-1:0]       rd_data_ff;
   logic                   mem_re, mem_we;
   logic [CH_W-1:0]        mem_waddr;
   logic [SUM_W-1:0]       mem_wdata;

   logic [CFG_COUNT_W-1:0] nl_lim;
   logic [SUM_W-1:0]       sum;
   logic [CFG_COUNT_W:0]   trial;
   logic                   q_bit;

   assign nl_lim    = clamp_count(cfg_integration_length, SPEC_LIMIT);
   assign sum       = rd_data_ff + SUM_W'(value_ff);
   assign trial     = {rem_ff, div_ff[SUM_W-1]};
   assign q_bit     = trial >= {1'b0, nl_lim};
   assign pop_ready = state_ff == ST_IDLE;
   assign mem_re    = pop_valid && pop_ready;
   assign mem_ready = state_ff != ST_CLEAR;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_average      = rsp_avg_ff;
   assign rsp_channel      = rsp_ch_ff;
   assign rsp_last_channel = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      value_in     = value_ff;
      channel_in   = channel_ff;
      flags_in     = flags_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = channel_ff;
      mem_wdata    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            if (clr_addr_ff == CH_W'(MAX_CHANNELS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + CH_W'(1);
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               value_in   = pop_value;
               channel_in = pop_channel;
               flags_in   = pop_flags;
               state_in   = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            mem_we    = 1'b1;
            mem_wdata = flags_ff.last_spec ? '0 : sum;
            div_in    = sum;
            rem_in    = '0;
            step_in   = '0;
            if (!flags_ff.last_spec) begin
               state_in = ST_IDLE;
            end else if (nl_lim == CFG_COUNT_W'(1)) begin
               state_in = ST_OUTPUT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = q_bit ? CFG_COUNT_W'(trial - {1'b0, nl_lim}) : trial[CFG_COUNT_W-1:0];
            div_in  = {div_ff[SUM_W-2:0], q_bit};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = VALUE_W'(div_ff);
               rsp_ch_in    = CHANNEL_W'(channel_ff);
               rsp_last_in  = flags_ff.last_chan;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      channel_ff  <= channel_in;
      flags_ff    <= flags_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= sums_mem[pop_channel];
      end
   end

endmodule

// ===== src/channel_time_integrator.sv =====
`timescale 1ns / 1ps
// channel_time_integrator: top level; holds the control registers and ties together
// cti_front, cti_queue and cti_back. Uses cti_pkg.
//
//  Channel  | Ports                               | Dir | Moves
//  ---------+-------------------------------------+-----+---------------------------------
//  request  | req_valid/req_ready, req_sample     | in  | one raw sample item, channel fastest
//  response | rsp_valid/rsp_ready, rsp_average,   | out | one channel average item
//           | rsp_channel, rsp_last_channel       |     |
//  control  | csr_valid/csr_ready, csr_index,     | in  | one register write item
//           | csr_wdata                           |     |
//
// Flow: the front takes one item per cycle into a 4-entry queue while it has room and
//   the memory clear is done. The back reads each item's sum from the single-port sum
//   memory, then adds and writes it back, and takes no new item until it is done.
//   An item on the last spectrum of a group also runs the bit-serial divider, one
//   quotient bit per cycle, unless integration_length acts as 1 and no divide is needed.
// Reset: the sum memory is cleared one entry a cycle; req_ready stays low until that is
//   done. Register writes are taken always.
// Stalls: the result register lets the back finish one more item while rsp_ready is low;
//   after that the back waits and the queue fills before req_ready drops.

module channel_time_integrator
   import cti_pkg::*;
#(
   parameter int MAX_CHANNELS    = DEFAULT_MAX_CHANNELS,
   parameter int MAX_INTEGRATION = DEFAULT_MAX_INTEGRATION
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_W-1:0]     rsp_average,
   output logic [CHANNEL_W-1:0]   rsp_channel,
   output logic                   rsp_last_channel,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ITEM_W = VALUE_W + CH_W + $bits(cti_flags_type);

   // control registers
   logic [CFG_COUNT_W-1:0] num_channels_ff, num_channels_in;
   logic [CFG_COUNT_W-1:0] integration_length_ff, integration_length_in;
   logic                   wide_samples_ff, wide_samples_in;
   logic                   mulaw_enable_ff, mulaw_enable_in;

   // front to queue
   logic                   push_valid, push_ready;
   logic [VALUE_W-1:0]     push_value;
   logic [CH_W-1:0]        push_channel;
   cti_flags_type          push_flags;

   // queue to back
   logic                   pop_valid, pop_ready;
   logic [ITEM_W-1:0]      pop_data;
   logic [VALUE_W-1:0]     pop_value;
   logic [CH_W-1:0]        pop_channel;
   cti_flags_type          pop_flags;

   logic                   mem_ready;

   // the control port never stalls
   assign csr_ready = 1'b1;

   always_comb begin
      num_channels_in       = num_channels_ff;
      integration_length_in = integration_length_ff;
      wide_samples_in       = wide_samples_ff;
      mulaw_enable_in       = mulaw_enable_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUM_CHANNELS:       num_channels_in       = csr_wdata;
            CSR_INTEGRATION_LENGTH: integration_length_in = csr_wdata;
            CSR_WIDE_SAMPLES:       wide_samples_in       = csr_wdata[0];
            CSR_MULAW_ENABLE:       mulaw_enable_in       = csr_wdata[0];
            default: begin
               // unmapped index: write is dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_channels_ff       <= RESET_NUM_CHANNELS;
         integration_length_ff <= RESET_INTEGRATION_LENGTH;
         wide_samples_ff       <= 1'b0;
         mulaw_enable_ff       <= 1'b0;
      end else begin
         num_channels_ff       <= num_channels_in;
         integration_length_ff <= integration_length_in;
         wide_samples_ff       <= wide_samples_in;
         mulaw_enable_ff       <= mulaw_enable_in;
      end
   end

   // front: expand sample, track position, flag last channel / last spectrum
   cti_front #(
      .MAX_CHANNELS    (MAX_CHANNELS),
      .MAX_INTEGRATION (MAX_INTEGRATION)
   ) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .cfg_num_channels       (num_channels_ff),
      .cfg_integration_length (integration_length_ff),
      .cfg_wide_samples       (wide_samples_ff),
      .cfg_mulaw_enable       (mulaw_enable_ff),
      .enable                 (mem_ready),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_sample             (req_sample),
      .push_valid             (push_valid),
      .push_ready             (push_ready),
      .push_value             (push_value),
      .push_channel           (push_channel),
      .push_flags             (push_flags)
   );

   // queue: decouples the per-cycle front from the multi-cycle back
   cti_queue #(
      .DATA_W (ITEM_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_value, push_channel, push_flags}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_value, pop_channel, pop_flags} = pop_data;

   // back: read-modify-write of the channel sum, divide, result register
   cti_back #(
      .MAX_CHANNELS    (MAX_CHANNELS),
      .MAX_INTEGRATION (MAX_INTEGRATION)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg_integration_length (integration_length_ff),
      .pop_valid              (pop_valid),
      .pop_ready              (pop_ready),
      .pop_value              (pop_value),
      .pop_channel            (pop_channel),
      .pop_flags              (pop_flags),
      .mem_ready              (mem_ready),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_average            (rsp_average),
      .rsp_channel            (rsp_channel),
      .rsp_last_channel       (rsp_last_channel)
   );

endmodule

// ===== src/cti_checker.sv =====
`timescale 1ns / 1ps
// cti_checker: port-level checks for channel_time_integrator, attached by bind.
// Uses cti_pkg for port widths.

module cti_checker
   import cti_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [VALUE_W-1:0]     rsp_average,
   input logic [CHANNEL_W-1:0]   rsp_channel,
   input logic                   rsp_last_channel
);

   logic [31:0] accepted_ff, delivered_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff  <= '0;
         delivered_ff <= '0;
      end else begin
         accepted_ff  <= accepted_ff + 32'(req_valid && req_ready);
         delivered_ff <= delivered_ff + 32'(rsp_valid && rsp_ready);
      end
   end

   // reset starts the memory clear: no item taken, no result shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("item path active right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average)
                                  && $stable(rsp_channel) && $stable(rsp_last_channel))
      else $error("stalled result item changed");

   // every result belongs to an item already taken
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> accepted_ff > delivered_ff)
      else $error("result item without a pending input item");

endmodule

bind channel_time_integrator cti_checker u_cti_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_average      (rsp_average),
   .rsp_channel      (rsp_channel),
   .rsp_last_channel (rsp_last_channel)
);

// ===== test/channel_time_integrator_tb.sv =====
`timescale 1ns / 1ps
// channel_time_integrator_tb: self-checking bench for channel_time_integrator. A local
// integration predictor computes the expected averages. Depends on cti_pkg and the RTL.

module channel_time_integrator_tb
   import cti_pkg::*;
;

   localparam int MAX_CH        = DEFAULT_MAX_CHANNELS;
   localparam int MAX_SPECTRA   = DEFAULT_MAX_INTEGRATION;
   localparam int RANDOM_ITEMS  = 480;
   // Deepest backlog: queue + back end + result register.
   localparam int SETTLE_CYCLES = 256;
   localparam int TIMEOUT_NS    = 20_000_000;

   typedef struct packed {
      logic [VALUE_W-1:0]   average;
      logic [CHANNEL_W-1:0] channel;
      logic                 last_channel;
   } channel_average_type;

   // Every DUT input holds a known value from time zero; reset starts asserted.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [VALUE_W-1:0]     rsp_average;
   logic [CHANNEL_W-1:0]   rsp_channel;
   logic                   rsp_last_channel;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor copy of the registers and of the integration state.
   logic [CFG_COUNT_W-1:0] cfg_num_channels = RESET_NUM_CHANNELS;
   logic [CFG_COUNT_W-1:0] cfg_integration  = RESET_INTEGRATION_LENGTH;
   logic                   cfg_wide         = 1'b0;
   logic                   cfg_mulaw        = 1'b0;
   longint unsigned        channel_sum [MAX_CH];
   int unsigned            chan_pos = 0;
   int unsigned            spec_pos = 0;

   channel_average_type    expected_averages [$];
   int                     error_count = 0;
   bit                     no_idle = 1'b0;  // steady stretch: both sides run flat out
   int                     stall_left = 0;

   channel_time_integrator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_channel      (rsp_channel),
      .rsp_last_channel (rsp_last_channel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #TIMEOUT_NS;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // mu 255 expansion of one byte to Q1.16, rounded to nearest
   function automatic logic [VALUE_W-1:0] mulaw_expand(input logic [7:0] code);
      real level;
      level = (256.0 ** (real'(code) / 255.0) - 1.0) * 65536.0 / 255.0;
      return VALUE_W'($rtoi(level + 0.5));
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0]  data);
      case (idx)
         CSR_NUM_CHANNELS:       cfg_num_channels = data;
         CSR_INTEGRATION_LENGTH: cfg_integration  = data;
         CSR_WIDE_SAMPLES:       cfg_wide         = data[0];
         CSR_MULAW_ENABLE:       cfg_mulaw        = data[0];
         default: ;
      endcase
   endfunction

   // Adds one accepted sample to its channel; on the last spectrum of a group the
   // floored average of that channel becomes an expected item and the sum clears.
   function automatic void integrate_sample(input logic [SAMPLE_W-1:0] sample);
      int unsigned         n_chan, n_spec, ch;
      longint unsigned     value;
      bit                  last_chan, last_spec;
      channel_average_type item;
      n_chan = (cfg_num_channels == 0) ? 1 : cfg_num_channels;
      if (n_chan > MAX_CH) n_chan = MAX_CH;
      n_spec = (cfg_integration == 0) ? 1 : cfg_integration;
      if (n_spec > MAX_SPECTRA) n_spec = MAX_SPECTRA;
      ch = (chan_pos >= MAX_CH) ? MAX_CH - 1 : chan_pos;

      if (cfg_wide)       value = 64'(sample);
      else if (cfg_mulaw) value = 64'(mulaw_expand(sample[7:0]));
      else                value = 64'(sample[7:0]);

      channel_sum[ch] += value;
      // positions past a shrunken limit count as the last one
      last_chan = (ch + 1 >= n_chan);
      last_spec = (spec_pos + 1 >= n_spec);

      if (last_spec) begin
         item.average      = VALUE_W'(channel_sum[ch] / n_spec);
         item.channel      = CHANNEL_W'(ch);
         item.last_channel = last_chan;
         expected_averages.push_back(item);
         channel_sum[ch] = 0;
      end

      if (last_chan) begin
         chan_pos = 0;
         spec_pos = last_spec ? 0 : spec_pos + 1;
      end else begin
         chan_pos = ch + 1;
      end
   endfunction

   // ---------------------------------------------------------------- result side

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic void check_average();
      channel_average_type want;
      if (expected_averages.size() == 0) begin
         $error("unexpected item: average %0d channel %0d last_channel %0b",
                rsp_average, rsp_channel, rsp_last_channel);
         error_count++;
      end else begin
         want = expected_averages.pop_front();
         if (rsp_average !== want.average) begin
            $error("average: expected %0d, actual %0d", want.average, rsp_average);
            error_count++;
         end
         if (rsp_channel !== want.channel) begin
            $error("channel: expected %0d, actual %0d", want.channel, rsp_channel);
            error_count++;
         end
         if (rsp_last_channel !== want.last_channel) begin
            $error("last_channel: expected %0b, actual %0b",
                   want.last_channel, rsp_last_channel);
            error_count++;
         end
      end
   endfunction

   // Outputs are sampled at the edge, before this edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_average();
   end

   // Receiver pacing: after each accepted item, hold ready low for a drawn count.
   always @(posedge clock) begin : rsp_pacing
      int pause;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else if (rsp_valid && rsp_ready) begin
         pause = draw_wait();
         stall_left <= pause;
         rsp_ready  <= (pause == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- drivers

   // Valid stays high across back-to-back items; it drops only ahead of a gap, and
   // every caller that lets time pass without sending lowers it first.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (!req_ready);
      integrate_sample(sample);
   endtask

   // All results in, then enough cycles for items that produce none to drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0]  data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
   endtask

   task automatic configure(input logic [CFG_COUNT_W-1:0] n_chan,
                            input logic [CFG_COUNT_W-1:0] n_spec,
                            input logic wide, input logic mulaw);
      wait_idle();
      write_register(CSR_NUM_CHANNELS, n_chan);
      write_register(CSR_INTEGRATION_LENGTH, n_spec);
      write_register(CSR_WIDE_SAMPLES, CSR_DATA_W'(wide));
      write_register(CSR_MULAW_ENABLE, CSR_DATA_W'(mulaw));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'(8'hFF);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // Power-up registers: 1024 channels, no integration, raw 8-bit samples.
   task automatic test_reset_defaults();
      send_sample(16'h0000);
      send_sample(16'hFFFF);   // upper byte ignored, 255
      send_sample(16'h5A00);   // low byte zero
   endtask

   // Channel count of zero acts as one, above 1024 acts as 1024, and a position
   // beyond a new, smaller count is taken as the last channel.
   task automatic test_channel_clamping();
      configure(0, 1, 1'b0, 1'b0);
      send_sample(16'h00A5);
      send_sample(16'h0001);
      configure(CFG_COUNT_W'(CFG_COUNT_MAX), 1, 1'b1, 1'b0);
      send_sample(16'hFFFF);
      send_sample(16'h8000);
      configure(2, 1, 1'b1, 1'b0);
      send_sample(16'h7FFF);
   endtask

   // Expansion ends (0 and 65536), mid code, upper byte ignored; then mu-law
   // requested in 16-bit mode, where samples pass unchanged.
   task automatic test_mulaw_expansion();
      configure(4, 1, 1'b0, 1'b1);
      send_sample(16'h0000);
      send_sample(16'h00FF);
      send_sample(16'h0080);
      send_sample(16'hFF01);
      configure(2, 1, 1'b1, 1'b1);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
   endtask

   // Length 1024 and a clamped 2047 hold the group open; shrinking it mid-group
   // closes it with the whole sum divided once and floored. Then zero acts as one.
   task automatic test_integration_clamping();
      configure(1, CFG_COUNT_W'(MAX_SPECTRA), 1'b0, 1'b0);
      send_sample(16'h00FF);
      send_sample(16'h00FF);
      configure(1, CFG_COUNT_W'(CFG_COUNT_MAX), 1'b0, 1'b0);
      send_sample(16'h00FF);
      send_sample(16'h00FF);
      configure(1, 3, 1'b0, 1'b0);
      send_sample(16'h00FE);   // 1274 / 3 floors to 424
      configure(1, 0, 1'b1, 1'b0);
      send_sample(16'hFFFF);
   endtask

   // Mostly whole groups from an aligned start with random content. Raw 8-bit
   // phases sometimes stop partway and are realigned by a one-channel flush, so
   // leftover sums stay small and every average fits its field.
   task automatic test_random_integration();
      int unsigned            sent, n_chan, n_spec, groups, tail;
      logic [CFG_COUNT_W-1:0] chan_reg, spec_reg;
      logic                   wide, mulaw;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       chan_reg = '0;
            1, 2:    chan_reg = CFG_COUNT_W'($urandom_range(9, 40));
            default: chan_reg = CFG_COUNT_W'($urandom_range(1, 8));
         endcase
         n_chan   = (chan_reg == 0) ? 1 : chan_reg;
         spec_reg = (n_chan > 8) ? CFG_COUNT_W'($urandom_range(0, 3))
                                 : CFG_COUNT_W'($urandom_range(0, 6));
         n_spec   = (spec_reg == 0) ? 1 : spec_reg;
         wide     = 1'($urandom_range(0, 1));
         mulaw    = 1'($urandom_range(0, 1));
         groups   = 120 / (n_chan * n_spec);
         groups   = $urandom_range(1, (groups < 1) ? 1 : (groups > 3) ? 3 : groups);

         configure(chan_reg, spec_reg, wide, mulaw);
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (groups * n_chan * n_spec) send_sample(random_sample());
         sent += groups * n_chan * n_spec;

         if (!wide && !mulaw && n_chan * n_spec > 1 && $urandom_range(0, 2) == 0) begin
            tail = $urandom_range(1, n_chan * n_spec - 1);
            repeat (tail) send_sample(random_sample());
            configure(1, 1, 1'b0, 1'b0);
            send_sample(random_sample());
            sent += tail + 1;
         end
         no_idle = 1'b0;
      end
   endtask

   task automatic finish_run();
      wait_idle();
      if (expected_averages.size() != 0) begin
         $error("%0d expected items never arrived", expected_averages.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   endtask

   initial begin
      foreach (channel_sum[i]) channel_sum[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_channel_clamping();
      test_mulaw_expansion();
      test_integration_clamping();
      test_random_integration();
      finish_run();
   end

endmodule
